/* rtl/uart_pkg.sv */
// Shared types and constants for the UART transceiver.
package uart_pkg;

    localparam int OVERSAMPLE    = 16;
    localparam int DIVISOR_WIDTH = 12;
    localparam int SAMP_W        = $clog2(OVERSAMPLE);

    localparam logic [2:0] CFG_ENABLE_MODE    = 3'd0;
    localparam logic [2:0] CFG_BAUD_DIVISOR   = 3'd1;
    localparam logic [2:0] CFG_DOUBLE_SPEED   = 3'd2;
    localparam logic [2:0] CFG_DATA_BITS      = 3'd3;
    localparam logic [2:0] CFG_PARITY_MODE    = 3'd4;
    localparam logic [2:0] CFG_TWO_STOP       = 3'd5;
    localparam logic [2:0] CFG_INTERRUPT_MASK = 3'd6;

    localparam logic [1:0] PAR_EVEN = 2'd1;
    localparam logic [1:0] PAR_ODD  = 2'd2;

    localparam logic [1:0] CODE_NONE    = 2'd0;
    localparam logic [1:0] CODE_FRAME   = 2'd1;
    localparam logic [1:0] CODE_OVERRUN = 2'd2;
    localparam logic [1:0] CODE_PARITY  = 2'd3;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [8:0] write_word;
        logic       rx_line;
    } item_t;

    typedef struct packed {
        logic       tx_line;
        logic [8:0] read_word;
        logic       buffer_empty;
        logic       tx_complete;
        logic       rx_complete;
        logic       frame_error;
        logic       overrun_error;
        logic       parity_error;
        logic [1:0] read_error_code;
        logic       interrupt_request;
    } result_t;

endpackage

/* rtl/uart_transceiver.sv */
// Top level of the UART transceiver: request queue in front of the UART core.
//
// Every input request is one tick of the UART's time base. It carries the
// sampled receive line (rx_line) and a host access in command: none, write
// write_word to the transmit buffer, or read the held received word.
// Every request gives exactly one result carrying tx_line, read_word, the
// status flags, read_error_code and interrupt_request as they stand after
// that tick.
// A request is taken on an edge where in_valid is high and in_stall low;
// a result is taken where out_valid is high and out_stall low.
// A request is registered in the request queue and its result in the result
// register; throughput is one request per cycle while out_stall does not hold
// a result, as the core registers update once per request.
// A two-entry request queue sits ahead of the core; with requests back to
// back, in_stall rises in the cycle after out_stall starts holding a result.
// Configuration writes (cfg_write_en, cfg_index, cfg_data) take effect at
// the next edge and are meant for idle periods.
// Reset clears the configuration to its defaults, empties the queue and the
// transmit buffer, idles both shifters (tx_shift_reg all ones), clears status.
module uart_transceiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [8:0]  write_word,
    input  logic        rx_line,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        tx_line,
    output logic [8:0]  read_word,
    output logic        buffer_empty,
    output logic        tx_complete,
    output logic        rx_complete,
    output logic        frame_error,
    output logic        overrun_error,
    output logic        parity_error,
    output logic [1:0]  read_error_code,
    output logic        interrupt_request
);
    import uart_pkg::*;

    item_t   q_item;
    logic    q_valid;
    logic    pop;
    result_t result;

    uart_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .write_word (write_word),
        .rx_line    (rx_line),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_item     (q_item)
    );

    uart_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result       (result)
    );

    assign tx_line           = result.tx_line;
    assign read_word         = result.read_word;
    assign buffer_empty      = result.buffer_empty;
    assign tx_complete       = result.tx_complete;
    assign rx_complete       = result.rx_complete;
    assign frame_error       = result.frame_error;
    assign overrun_error     = result.overrun_error;
    assign parity_error      = result.parity_error;
    assign read_error_code   = result.read_error_code;
    assign interrupt_request = result.interrupt_request;

endmodule

/* rtl/uart_front.sv */
// Request intake: command decode and a two-entry queue toward the core.
module uart_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [1:0]     command,
    input  logic [8:0]     write_word,
    input  logic           rx_line,
    input  logic           pop,
    output logic           q_valid,
    output uart_pkg::item_t q_item
);
    import uart_pkg::*;

    item_t      slot_reg [2];
    item_t      item_in;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       do_pop;

    always_comb
    begin
        case (command)
            CMD_WRITE: item_in.cmd = CMD_WRITE;
            CMD_READ:  item_in.cmd = CMD_READ;
            default:   item_in.cmd = CMD_NONE;
        endcase
        item_in.write_word = write_word;
        item_in.rx_line    = rx_line;
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign do_pop   = pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

/* rtl/uart_core.sv */
// Core: configuration, transmitter, receiver and the result register.
module uart_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [2:0]        cfg_index,
    input  logic [11:0]       cfg_data,
    input  logic              q_valid,
    input  uart_pkg::item_t   q_item,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output uart_pkg::result_t result
);
    import uart_pkg::*;

    localparam int DIV_W = DIVISOR_WIDTH;
    localparam logic [SAMP_W-1:0] OS_LAST      = SAMP_W'(OVERSAMPLE - 1);
    localparam logic [SAMP_W-1:0] OS_HALF_LAST = SAMP_W'(OVERSAMPLE / 2 - 1);
    localparam logic [SAMP_W-1:0] OS_HALF      = SAMP_W'(OVERSAMPLE / 2);
    localparam logic [SAMP_W-1:0] OS_QUARTER   = SAMP_W'(OVERSAMPLE / 4);

    logic [1:0]  enable_reg;
    logic [11:0] baud_reg;
    logic        double_reg;
    logic [3:0]  data_bits_reg;
    logic [1:0]  parity_reg;
    logic        two_stop_reg;
    logic [2:0]  mask_reg;

    logic [DIV_W-1:0]  tx_baud_reg, tx_baud_next;
    logic [SAMP_W-1:0] tx_samp_reg, tx_samp_next;
    logic [12:0]       tx_shift_reg, tx_shift_next;
    logic [3:0]        tx_left_reg, tx_left_next;
    logic [8:0]        tx_buf_reg, tx_buf_next;
    logic              tx_full_reg, tx_full_next;
    logic              tx_done_reg, tx_done_next;
    logic [DIV_W-1:0]  rx_baud_reg, rx_baud_next;
    logic [SAMP_W-1:0] rx_samp_reg, rx_samp_next;
    logic [9:0]        rx_shift_reg, rx_shift_next;
    logic [3:0]        rx_seen_reg, rx_seen_next;
    logic [8:0]        rx_hold_reg, rx_hold_next;
    logic [3:0]        rx_status_reg, rx_status_next;
    logic              out_valid_reg;
    result_t           result_reg, result_next;

    logic              advance;
    logic [DIV_W+11:0] div_ext;
    logic [DIV_W-1:0]  div_val;
    logic [SAMP_W-1:0] os_last;
    logic [SAMP_W-1:0] os_half;
    logic [3:0]        nbits;
    logic              par_on;
    logic [8:0]        data_mask;

    assign advance   = q_valid && (!out_valid_reg || !out_stall);
    assign pop       = advance;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    assign div_ext = {{DIV_W{1'b0}}, baud_reg};
    assign div_val = div_ext[DIV_W-1:0];
    assign os_last = double_reg ? OS_HALF_LAST : OS_LAST;
    assign os_half = double_reg ? OS_QUARTER : OS_HALF;
    assign par_on  = (parity_reg == PAR_EVEN) || (parity_reg == PAR_ODD);

    always_comb
    begin
        if (data_bits_reg < 4'd5)
            nbits = 4'd5;
        else if (data_bits_reg > 4'd9)
            nbits = 4'd9;
        else
            nbits = data_bits_reg;
        for (int i = 0; i < 9; i++)
            data_mask[i] = (4'(i) < nbits);
    end

    always_comb
    begin
        logic        tick;
        logic [8:0]  data;
        logic [12:0] data_ext;
        logic        pb;
        logic [3:0]  idx;
        logic        fe;
        logic        pe;
        logic        rxl;

        tx_baud_next   = tx_baud_reg;
        tx_samp_next   = tx_samp_reg;
        tx_shift_next  = tx_shift_reg;
        tx_left_next   = tx_left_reg;
        tx_buf_next    = tx_buf_reg;
        tx_full_next   = tx_full_reg;
        tx_done_next   = tx_done_reg;
        rx_baud_next   = rx_baud_reg;
        rx_samp_next   = rx_samp_reg;
        rx_shift_next  = rx_shift_reg;
        rx_seen_next   = rx_seen_reg;
        rx_hold_next   = rx_hold_reg;
        rx_status_next = rx_status_reg;
        result_next    = '0;
        result_next.tx_line = 1'b1;
        tick     = 1'b0;
        data     = '0;
        data_ext = '0;
        pb       = 1'b0;
        idx      = '0;
        fe       = 1'b0;
        pe       = 1'b0;
        rxl      = q_item.rx_line;

        if (!enable_reg[1])
        begin
            tx_baud_next  = '0;
            tx_samp_next  = '0;
            tx_shift_next = '1;
            tx_left_next  = '0;
            tx_full_next  = 1'b0;
        end
        else
        begin
            if (q_item.cmd == CMD_WRITE && !tx_full_reg)
            begin
                tx_buf_next  = q_item.write_word;
                tx_full_next = 1'b1;
                tx_done_next = 1'b0;
            end
            if (tx_left_reg != 4'd0)
            begin
                tick = (tx_baud_reg == '0);
                tx_baud_next = tick ? div_val : tx_baud_reg - 1'b1;
                if (tick)
                begin
                    if (tx_samp_reg >= os_last)
                    begin
                        tx_samp_next  = '0;
                        tx_shift_next = {1'b1, tx_shift_reg[12:1]};
                        tx_left_next  = tx_left_reg - 4'd1;
                        if (tx_left_next == 4'd0 && !tx_full_next)
                            tx_done_next = 1'b1;
                    end
                    else
                    begin
                        tx_samp_next = tx_samp_reg + 1'b1;
                    end
                end
            end
            if (tx_left_next == 4'd0 && tx_full_next)
            begin
                data     = tx_buf_next & data_mask;
                data_ext = {4'b0, data};
                pb       = (^data) ^ (parity_reg == PAR_ODD);
                for (int i = 0; i < 13; i++)
                begin
                    if (i == 0)
                        tx_shift_next[i] = 1'b0;
                    else if (4'(i) <= nbits)
                        tx_shift_next[i] = data_ext[i-1];
                    else if (par_on && 4'(i) == nbits + 4'd1)
                        tx_shift_next[i] = pb;
                    else
                        tx_shift_next[i] = 1'b1;
                end
                tx_left_next = nbits + 4'd2 + {3'b0, par_on} + {3'b0, two_stop_reg};
                tx_full_next = 1'b0;
                tx_samp_next = '0;
                tx_baud_next = div_val;
            end
            result_next.tx_line = tx_shift_next[0];
        end

        if (!enable_reg[0])
        begin
            rx_baud_next   = '0;
            rx_samp_next   = '0;
            rx_shift_next  = '0;
            rx_seen_next   = '0;
            rx_status_next = '0;
        end
        else
        begin
            tick = (rx_baud_reg == '0);
            rx_baud_next = tick ? div_val : rx_baud_reg - 1'b1;
            if (tick)
            begin
                if (rx_seen_reg == 4'd0)
                begin
                    if (!rxl)
                    begin
                        rx_seen_next  = 4'd1;
                        rx_samp_next  = os_half;
                        rx_shift_next = '0;
                    end
                end
                else if (rx_samp_reg < os_last)
                begin
                    rx_samp_next = rx_samp_reg + 1'b1;
                end
                else
                begin
                    rx_samp_next = '0;
                    if (rx_seen_reg == 4'd1)
                    begin
                        rx_seen_next = rxl ? 4'd0 : 4'd2;
                    end
                    else
                    begin
                        idx = rx_seen_reg - 4'd2;
                        if (idx < nbits + {3'b0, par_on} && idx < 4'd10)
                        begin
                            for (int i = 0; i < 10; i++)
                                if (idx == 4'(i))
                                    rx_shift_next[i] = rx_shift_reg[i] | rxl;
                            rx_seen_next = rx_seen_reg + 4'd1;
                        end
                        else
                        begin
                            data = rx_shift_reg[8:0] & data_mask;
                            fe   = !rxl;
                            if (par_on)
                                pe = (^data) ^ rx_shift_reg[nbits] ^ (parity_reg == PAR_ODD);
                            if (rx_status_reg[0])
                            begin
                                rx_status_next = rx_status_reg | 4'b0100;
                            end
                            else
                            begin
                                rx_hold_next   = data;
                                rx_status_next = {pe, 1'b0, fe, 1'b1};
                            end
                            rx_seen_next  = '0;
                            rx_shift_next = '0;
                        end
                    end
                end
            end
        end

        if (q_item.cmd == CMD_READ && rx_status_next[0])
        begin
            result_next.read_word = rx_hold_next;
            if (rx_status_next[1])
                result_next.read_error_code = CODE_FRAME;
            else if (rx_status_next[2])
                result_next.read_error_code = CODE_OVERRUN;
            else if (rx_status_next[3])
                result_next.read_error_code = CODE_PARITY;
            else
                result_next.read_error_code = CODE_NONE;
            rx_status_next = '0;
        end

        result_next.buffer_empty  = !tx_full_next;
        result_next.tx_complete   = tx_done_next;
        result_next.rx_complete   = rx_status_next[0];
        result_next.frame_error   = rx_status_next[1];
        result_next.overrun_error = rx_status_next[2];
        result_next.parity_error  = rx_status_next[3];
        result_next.interrupt_request = (mask_reg[0] && rx_status_next[0])
            || (mask_reg[1] && !tx_full_next) || (mask_reg[2] && tx_done_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= '0;
            baud_reg      <= '0;
            double_reg    <= 1'b0;
            data_bits_reg <= 4'd5;
            parity_reg    <= '0;
            two_stop_reg  <= 1'b0;
            mask_reg      <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_ENABLE_MODE:    enable_reg    <= cfg_data[1:0];
                CFG_BAUD_DIVISOR:   baud_reg      <= cfg_data;
                CFG_DOUBLE_SPEED:   double_reg    <= cfg_data[0];
                CFG_DATA_BITS:      data_bits_reg <= cfg_data[3:0];
                CFG_PARITY_MODE:    parity_reg    <= cfg_data[1:0];
                CFG_TWO_STOP:       two_stop_reg  <= cfg_data[0];
                CFG_INTERRUPT_MASK: mask_reg      <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_baud_reg   <= '0;
            tx_samp_reg   <= '0;
            tx_shift_reg  <= '1;
            tx_left_reg   <= '0;
            tx_full_reg   <= 1'b0;
            tx_done_reg   <= 1'b0;
            rx_baud_reg   <= '0;
            rx_samp_reg   <= '0;
            rx_shift_reg  <= '0;
            rx_seen_reg   <= '0;
            rx_status_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                tx_baud_reg   <= tx_baud_next;
                tx_samp_reg   <= tx_samp_next;
                tx_shift_reg  <= tx_shift_next;
                tx_left_reg   <= tx_left_next;
                tx_full_reg   <= tx_full_next;
                tx_done_reg   <= tx_done_next;
                rx_baud_reg   <= rx_baud_next;
                rx_samp_reg   <= rx_samp_next;
                rx_shift_reg  <= rx_shift_next;
                rx_seen_reg   <= rx_seen_next;
                rx_status_reg <= rx_status_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tx_buf_reg  <= tx_buf_next;
            rx_hold_reg <= rx_hold_next;
            result_reg  <= result_next;
        end
    end

endmodule

/* rtl/uart_checker.sv */
// Port-level assertions for the UART transceiver, bound to the top level.
module uart_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [8:0] read_word,
    input logic       buffer_empty,
    input logic       tx_complete,
    input logic       rx_complete,
    input logic       frame_error,
    input logic       overrun_error,
    input logic       parity_error,
    input logic [1:0] read_error_code
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_word))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_error_code != 2'd0
        |-> !rx_complete && !frame_error && !overrun_error && !parity_error)
    else $error("read left status flags set");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_complete |-> buffer_empty)
    else $error("transmit complete with full buffer");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (overrun_error || frame_error || parity_error) |-> rx_complete)
    else $error("error flag without held word");

endmodule

bind uart_transceiver uart_checker u_chk (.*);

/* dv/tb.sv */
// Testbench for uart_transceiver: random serial traffic and host accesses checked per tick.
`timescale 1ns / 1ps

module tb;
    import uart_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 64;

    // Mirror of the transceiver: configuration, both shifters, status and the
    // per-tick outputs still waiting to come out of the block.
    class uart_shadow;
        bit [1:0]  en_mode;
        bit [11:0] baud_div;
        bit        half_os;
        bit [3:0]  word_bits;
        bit [1:0]  par_mode;
        bit        stop_two;
        bit [2:0]  irq_mask;

        bit [11:0] tx_baud;
        bit [3:0]  tx_samp;
        bit [12:0] tx_sr;
        bit [3:0]  tx_left;
        bit [8:0]  tx_buf;
        bit        tx_full;
        bit        tx_done;

        bit [11:0] rx_baud;
        bit [3:0]  rx_samp;
        bit [9:0]  rx_sr;
        bit [3:0]  rx_pos;
        bit [8:0]  rx_hold;
        bit [3:0]  rx_stat;

        result_t tick_results_q[$];
        int      errors;

        function new();
            en_mode   = '0;
            baud_div  = '0;
            half_os   = 1'b0;
            word_bits = 4'd5;
            par_mode  = '0;
            stop_two  = 1'b0;
            irq_mask  = '0;
            tx_baud   = '0;
            tx_samp   = '0;
            tx_sr     = '1;
            tx_left   = '0;
            tx_buf    = '0;
            tx_full   = 1'b0;
            tx_done   = 1'b0;
            rx_baud   = '0;
            rx_samp   = '0;
            rx_sr     = '0;
            rx_pos    = '0;
            rx_hold   = '0;
            rx_stat   = '0;
            errors    = 0;
        endfunction

        function int sample_ticks();
            return half_os ? OVERSAMPLE / 2 : OVERSAMPLE;
        endfunction

        function int frame_bits();
            if (word_bits < 5)
                return 5;
            if (word_bits > 9)
                return 9;
            return int'(word_bits);
        endfunction

        function int pending();
            return tick_results_q.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [11:0] value);
            case (idx)
                CFG_ENABLE_MODE:    en_mode   = value[1:0];
                CFG_BAUD_DIVISOR:   baud_div  = value;
                CFG_DOUBLE_SPEED:   half_os   = value[0];
                CFG_DATA_BITS:      word_bits = value[3:0];
                CFG_PARITY_MODE:    par_mode  = value[1:0];
                CFG_TWO_STOP:       stop_two  = value[0];
                CFG_INTERRUPT_MASK: irq_mask  = value[2:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic [1:0] cmd, logic [8:0] word, logic rxl);
            int       os;
            int       nd;
            int       pos;
            int       idx;
            int       fr;
            bit       par;
            bit       tick;
            bit       fe;
            bit       pe;
            bit       pb;
            bit [8:0] data;
            result_t  r;
            os  = sample_ticks();
            nd  = frame_bits();
            par = (par_mode == PAR_EVEN) || (par_mode == PAR_ODD);
            r   = '0;
            r.tx_line = 1'b1;
            r.read_error_code = CODE_NONE;

            if (!en_mode[1])
            begin
                tx_baud = '0;
                tx_samp = '0;
                tx_sr   = '1;
                tx_left = '0;
                tx_full = 1'b0;
            end
            else
            begin
                if (cmd == CMD_WRITE && !tx_full)
                begin
                    tx_buf  = word;
                    tx_full = 1'b1;
                    tx_done = 1'b0;
                end
                if (tx_left != 0)
                begin
                    tick    = (tx_baud == 0);
                    tx_baud = tick ? baud_div : tx_baud - 1'b1;
                    if (tick)
                    begin
                        if (int'(tx_samp) >= os - 1)
                        begin
                            tx_samp = '0;
                            tx_sr   = {1'b1, tx_sr[12:1]};
                            tx_left--;
                            if (tx_left == 0 && !tx_full)
                                tx_done = 1'b1;
                        end
                        else
                        begin
                            tx_samp++;
                        end
                    end
                end
                if (tx_left == 0 && tx_full)
                begin
                    data = tx_buf & 9'((1 << nd) - 1);
                    fr   = int'(data) << 1;
                    pos  = nd + 1;
                    if (par)
                    begin
                        pb  = ^data ^ (par_mode == PAR_ODD);
                        fr  = fr | (int'(pb) << pos);
                        pos = pos + 1;
                    end
                    fr      = fr | (32'h1FFF << pos);
                    tx_sr   = fr[12:0];
                    tx_left = 4'(pos + 1 + int'(stop_two));
                    tx_full = 1'b0;
                    tx_samp = '0;
                    tx_baud = baud_div;
                end
                r.tx_line = tx_sr[0];
            end

            if (!en_mode[0])
            begin
                rx_baud = '0;
                rx_samp = '0;
                rx_sr   = '0;
                rx_pos  = '0;
                rx_stat = '0;
            end
            else
            begin
                tick    = (rx_baud == 0);
                rx_baud = tick ? baud_div : rx_baud - 1'b1;
                if (tick)
                begin
                    if (rx_pos == 0)
                    begin
                        if (!rxl)
                        begin
                            rx_pos  = 4'd1;
                            rx_samp = 4'(os / 2);
                            rx_sr   = '0;
                        end
                    end
                    else if (int'(rx_samp) < os - 1)
                    begin
                        rx_samp++;
                    end
                    else
                    begin
                        rx_samp = '0;
                        if (rx_pos == 1)
                        begin
                            rx_pos = rxl ? 4'd0 : 4'd2;
                        end
                        else
                        begin
                            idx = int'(rx_pos) - 2;
                            if (idx < nd + int'(par) && idx < 10)
                            begin
                                rx_sr[4'(idx)] = rxl;
                                rx_pos++;
                            end
                            else
                            begin
                                data = rx_sr[8:0] & 9'((1 << nd) - 1);
                                fe   = !rxl;
                                pe   = par && (^data ^ rx_sr[4'(nd)] ^ (par_mode == PAR_ODD));
                                if (rx_stat[0])
                                begin
                                    rx_stat[2] = 1'b1;
                                end
                                else
                                begin
                                    rx_hold = data;
                                    rx_stat = {pe, 1'b0, fe, 1'b1};
                                end
                                rx_pos = '0;
                                rx_sr  = '0;
                            end
                        end
                    end
                end
            end

            if (cmd == CMD_READ && rx_stat[0])
            begin
                r.read_word = rx_hold;
                if (rx_stat[1])
                    r.read_error_code = CODE_FRAME;
                else if (rx_stat[2])
                    r.read_error_code = CODE_OVERRUN;
                else if (rx_stat[3])
                    r.read_error_code = CODE_PARITY;
                rx_stat = '0;
            end

            r.buffer_empty      = !tx_full;
            r.tx_complete       = tx_done;
            r.rx_complete       = rx_stat[0];
            r.frame_error       = rx_stat[1];
            r.overrun_error     = rx_stat[2];
            r.parity_error      = rx_stat[3];
            r.interrupt_request = (irq_mask[0] && rx_stat[0]) || (irq_mask[1] && !tx_full)
                                  || (irq_mask[2] && tx_done);
            tick_results_q.push_back(r);
        endfunction

        function string show(result_t v);
            return {$sformatf("tx=%0b rd=%03h be=%0b tc=%0b rc=%0b ",
                              v.tx_line, v.read_word, v.buffer_empty, v.tx_complete,
                              v.rx_complete),
                    $sformatf("fe=%0b oe=%0b pe=%0b code=%0d irq=%0b",
                              v.frame_error, v.overrun_error, v.parity_error,
                              v.read_error_code, v.interrupt_request)};
        endfunction

        function void check_result(result_t got);
            result_t want;
            bit      bad;
            if (tick_results_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result with no request pending: %s", show(got));
                return;
            end
            want = tick_results_q.pop_front();
            bad  = (got.tx_line !== want.tx_line) || (got.read_word !== want.read_word)
                   || (got.buffer_empty !== want.buffer_empty)
                   || (got.tx_complete !== want.tx_complete)
                   || (got.rx_complete !== want.rx_complete)
                   || (got.frame_error !== want.frame_error)
                   || (got.overrun_error !== want.overrun_error)
                   || (got.parity_error !== want.parity_error)
                   || (got.read_error_code !== want.read_error_code)
                   || (got.interrupt_request !== want.interrupt_request);
            if (bad)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR: result mismatch at %0t", $realtime);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [8:0]  write_word;
    logic        rx_line;
    logic        out_valid;
    logic        out_stall;
    logic        tx_line;
    logic [8:0]  read_word;
    logic        buffer_empty;
    logic        tx_complete;
    logic        rx_complete;
    logic        frame_error;
    logic        overrun_error;
    logic        parity_error;
    logic [1:0]  read_error_code;
    logic        interrupt_request;

    uart_shadow  sb;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_request;
    int          quiet_cycles = 0;

    logic        rx_level_q[$];
    int unsigned rx_len_q[$];
    logic        rx_level;
    int unsigned rx_left;

    uart_transceiver dut (.*);

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_request(input logic [1:0] cmd, input logic [8:0] word,
                                input logic rxl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        write_word <= word;
        rx_line    <= rxl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(cmd, word, rxl);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input int value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value[11:0];
        sb.write_reg(idx, value[11:0]);
        @(negedge clk);
    endtask

    task automatic set_format(input int mode, input int div, input int ds, input int nb,
                              input int par, input int st, input int mask);
        put_reg(CFG_ENABLE_MODE, mode);
        put_reg(CFG_BAUD_DIVISOR, div);
        put_reg(CFG_DOUBLE_SPEED, ds);
        put_reg(CFG_DATA_BITS, nb);
        put_reg(CFG_PARITY_MODE, par);
        put_reg(CFG_TWO_STOP, st);
        put_reg(CFG_INTERRUPT_MASK, mask);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    function automatic void add_seg(input logic lvl, input int unsigned n);
        rx_level_q.push_back(lvl);
        rx_len_q.push_back(n);
    endfunction

    // Queue the next stretch of serial input: mostly clean frames at the
    // configured rate, some with bad parity or a low stop bit, glitches, noise.
    function automatic void queue_rx_traffic();
        int unsigned bit_len;
        int unsigned nd;
        int unsigned data;
        int unsigned kind;
        int unsigned k;
        int unsigned count;
        logic        pbit;
        bit_len = (sb.baud_div + 1) * sb.sample_ticks();
        nd      = sb.frame_bits();
        kind    = $urandom_range(99);
        if (kind < 8)
        begin
            add_seg(1'b0, $urandom_range(bit_len / 2, 1));
            add_seg(1'b1, bit_len * 2);
        end
        else if (kind < 13)
        begin
            count = $urandom_range(8, 2);
            for (k = 0; k < count; k++)
                add_seg(1'($urandom_range(1)), $urandom_range(bit_len, 1));
            add_seg(1'b1, bit_len * 14);
        end
        else
        begin
            data = $urandom_range((1 << nd) - 1);
            add_seg(1'b0, bit_len);
            for (k = 0; k < nd; k++)
                add_seg(data[5'(k)], bit_len);
            if (sb.par_mode == PAR_EVEN || sb.par_mode == PAR_ODD)
            begin
                pbit = ^data ^ (sb.par_mode == PAR_ODD);
                if (kind < 22)
                    pbit = !pbit;
                add_seg(pbit, bit_len);
            end
            if (kind < 30)
                add_seg(1'b0, bit_len);
            add_seg(1'b1, bit_len * $urandom_range(3, 1));
        end
    endfunction

    function automatic logic next_rx_level();
        if (rx_left == 0)
        begin
            if (rx_level_q.size() == 0)
                queue_rx_traffic();
            rx_level = rx_level_q.pop_front();
            rx_left  = rx_len_q.pop_front();
        end
        rx_left--;
        return rx_level;
    endfunction

    task automatic run_phase(input int mode, input int div, input int ds, input int nb,
                             input int par, input int st, input int mask, input int n,
                             input bit hold);
        int         k;
        int         r;
        logic [1:0] cmd;
        drain();
        set_format(mode, div, ds, nb, par, st, mask);
        rx_level_q.delete();
        rx_len_q.delete();
        rx_left = 0;
        hold_request = hold;
        for (k = 0; k < n; k++)
        begin
            r   = $urandom_range(99);
            cmd = (r < 3) ? CMD_WRITE : (r < 5) ? CMD_READ : CMD_NONE;
            send_request(cmd, 9'($urandom_range(511)), next_rx_level());
        end
    endtask

    // Receiver side: random stall, or one long hold-off when asked.
    initial
    begin
        int k;
        bit hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(negedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.tx_line           = tx_line;
            got.read_word         = read_word;
            got.buffer_empty      = buffer_empty;
            got.tx_complete       = tx_complete;
            got.rx_complete       = rx_complete;
            got.frame_error       = frame_error;
            got.overrun_error     = overrun_error;
            got.parity_error      = parity_error;
            got.read_error_code   = read_error_code;
            got.interrupt_request = interrupt_request;
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        sb            = new();
        send_idle_pct = 14;
        recv_idle_pct = 48;
        hold_request  = 1'b0;
        rx_left       = 0;
        rst_n         = 1'b0;
        cfg_write_en  = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        command       = CMD_NONE;
        write_word    = '0;
        rx_line       = 1'b1;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_format(3, 0, 1, 5, 0, 0, 7);
        send_request(CMD_READ, 9'h000, 1'b1);
        send_request(CMD_NONE, 9'h1FF, 1'b1);
        send_request(CMD_WRITE, 9'h000, 1'b1);
        send_request(CMD_WRITE, 9'h1FF, 1'b1);
        send_request(CMD_WRITE, 9'h0AA, 1'b0);
        send_request(CMD_NONE, 9'h155, 1'b0);
        repeat (6) send_request(CMD_NONE, 9'h000, 1'b1);
        send_request(CMD_READ, 9'h1FF, 1'b1);
        send_request(CMD_WRITE, 9'h155, 1'b1);

        run_phase(3, 0, 1, 5, 0, 0, 7, 200, 1'b0);
        run_phase(3, 0, 1, 9, 1, 1, 1, 200, 1'b0);
        run_phase(3, 1, 1, 8, 2, 0, 2, 200, 1'b0);
        run_phase(3, 0, 0, 7, 1, 0, 4, 200, 1'b0);

        send_idle_pct = 48;
        recv_idle_pct = 14;
        run_phase(1, 0, 1, 6, 2, 1, 5, 150, 1'b0);
        run_phase(2, 0, 1, 9, 2, 1, 3, 150, 1'b0);
        run_phase(3, 4095, 0, 9, 1, 1, 6, 60, 1'b0);
        run_phase(0, 4095, 1, 5, 0, 0, 7, 40, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(3, 0, 1, 8, 1, 0, 7, 250, 1'b1);
        run_phase(3, 2, 1, 5, 2, 1, 0, 200, 1'b0);
        run_phase(3, 0, 1, 9, 0, 1, 7, 200, 1'b0);

        drain();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
rtl/uart_pkg.sv
rtl/uart_front.sv
rtl/uart_core.sv
rtl/uart_transceiver.sv
rtl/uart_checker.sv
dv/tb.sv
